@@ sv/lfps_pkg.sv @@
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, constants and a helper function of the steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF   = 10;
   localparam int INTEGRAL_BITS_DEF = 32;

   // sensor array and centroid
   localparam int NUM_SAMPLES  = 7;
   localparam int WEIGHT_STEP  = 1000;
   localparam int WEIGHT_BITS  = 13;
   localparam int CENTRE       = 3000;
   localparam int POS_BITS     = 13;
   localparam int ERR_BITS     = 13;
   localparam int DERIV_BITS   = 14;
   localparam int QUOT_BITS    = 13;
   localparam int CNT_BITS     = 4;
   localparam int PID_STEPS    = 8;

   // gains, multiplier and accumulator
   localparam int GAIN_BITS     = 16;
   localparam int FRAC_BITS     = 12;
   localparam int ISUM_EXT_BITS = 48;
   localparam int SLICE_BITS    = 24;
   localparam int MUL_A_BITS    = GAIN_BITS + 1;
   localparam int MUL_B_BITS    = SLICE_BITS + 1;
   localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS      = 64;
   localparam logic signed [ACC_BITS-1:0] TERM_LIMIT = 64'sh0000_0100_0000_0000;

   // duties and output beat
   localparam int DUTY_BITS     = 8;
   localparam int RSP_DATA_BITS = 48;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [GAIN_BITS-1:0] KP_RESET   = 16'd205;
   localparam logic [GAIN_BITS-1:0] KI_RESET   = 16'd0;
   localparam logic [GAIN_BITS-1:0] KD_RESET   = 16'd410;
   localparam logic [DUTY_BITS-1:0] BASE_RESET = 8'd120;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KP   = 2'd0,
      CSR_KI   = 2'd1,
      CSR_KD   = 2'd2,
      CSR_BASE = 2'd3
   } lfps_csr_idx_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] kp;
      logic [GAIN_BITS-1:0] ki;
      logic [GAIN_BITS-1:0] kd;
      logic [DUTY_BITS-1:0] base;
   } lfps_cfg_type;

   // multiplier operand select
   typedef enum logic [1:0] {
      MUL_KI_LO = 2'd0,
      MUL_KI_HI = 2'd1,
      MUL_KP    = 2'd2,
      MUL_KD    = 2'd3
   } lfps_mul_sel_type;

   // accumulator operation
   typedef enum logic [2:0] {
      ACC_HOLD   = 3'd0,
      ACC_LOAD   = 3'd1,
      ACC_ADD    = 3'd2,
      ACC_ADD_HI = 3'd3,
      ACC_CLAMP  = 3'd4
   } lfps_acc_op_type;

   // controller states
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_SUM  = 9'b000000010,
      S_DVI  = 9'b000000100,
      S_DIV  = 9'b000001000,
      S_POS  = 9'b000010000,
      S_ERR  = 9'b000100000,
      S_INT  = 9'b001000000,
      S_PID  = 9'b010000000,
      S_OUT  = 9'b100000000
   } lfps_state_type;

   typedef struct packed {
      logic             load;
      logic             sum_en;
      logic [2:0]       sum_sel;
      logic             div_init;
      logic             div_step;
      logic             pos_upd;
      logic             err_calc;
      logic             int_upd;
      logic             mul_en;
      lfps_mul_sel_type mul_sel;
      lfps_acc_op_type  acc_op;
      logic             out_load;
   } lfps_cmd_type;

   typedef struct packed {
      logic total_zero;
   } lfps_sts_type;

   // sensor weight, 1000 per position
   function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [2:0] k);
      logic [WEIGHT_BITS-1:0] w;
      case (k)
         3'd0:    w = 13'd0;
         3'd1:    w = 13'd1000;
         3'd2:    w = 13'd2000;
         3'd3:    w = 13'd3000;
         3'd4:    w = 13'd4000;
         3'd5:    w = 13'd5000;
         3'd6:    w = 13'd6000;
         default: w = 13'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ sv/line_follower_pid_steering.sv @@
// ----------------------------------------------------------------------------
// line_follower_pid_steering
// Weighted-centroid line position and PID steering to two motor duties.
//
//   channel  direction  beat contents
//   req_     in         tdata: seven samples; tuser: restart flag
//   rsp_     out        tdata: left, right duty, line position, line error
//   csr_     in         index 0..3 (kp, ki, kd, base speed), 16-bit data
//
// An item is accepted in idle and then passes through the sums, the restoring
// divider (set-up, then one quotient bit a cycle), the error update, the
// shared multiplier and accumulator and the load of the output register;
// the block returns to idle before the next item can be taken.
// The result sits in an output register; the next item is accepted while it
// waits, and only the final load stalls behind an untaken result.
// Reset clears the gains to their defaults and the PID state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_pid_steering #(
   parameter int SAMPLE_BITS   = lfps_pkg::SAMPLE_BITS_DEF,
   parameter int INTEGRAL_BITS = lfps_pkg::INTEGRAL_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // sample_one .. sample_seven, then zero fill
   input  wire logic [((lfps_pkg::NUM_SAMPLES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // restart
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // left_speed, right_speed, line_position, line_error, then zero fill
   output logic [lfps_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lfps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   lfps_pkg::lfps_cfg_type cfg;
   lfps_pkg::lfps_cmd_type cmd;
   lfps_pkg::lfps_sts_type sts;

   // configuration registers
   lfps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   lfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   lfps_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ sv/lfps_csr.sv @@
// ----------------------------------------------------------------------------
// lfps_csr
// Gain and base speed registers behind the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lfps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output lfps_pkg::lfps_cfg_type                    cfg
);

   lfps_pkg::lfps_cfg_type cfg_ff;
   lfps_pkg::lfps_cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lfps_pkg::CSR_KP:   cfg_in.kp   = csr_data;
            lfps_pkg::CSR_KI:   cfg_in.ki   = csr_data;
            lfps_pkg::CSR_KD:   cfg_in.kd   = csr_data;
            lfps_pkg::CSR_BASE: cfg_in.base = csr_data[lfps_pkg::DUTY_BITS-1:0];
            default:            cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp   <= lfps_pkg::KP_RESET;
         cfg_ff.ki   <= lfps_pkg::KI_RESET;
         cfg_ff.kd   <= lfps_pkg::KD_RESET;
         cfg_ff.base <= lfps_pkg::BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lfps_dp.sv @@
// ----------------------------------------------------------------------------
// lfps_dp
// Datapath: centroid sums, restoring divider, PID state, shared multiplier,
// accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_dp #(
   parameter int SAMPLE_BITS   = lfps_pkg::SAMPLE_BITS_DEF,
   parameter int INTEGRAL_BITS = lfps_pkg::INTEGRAL_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [((lfps_pkg::NUM_SAMPLES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                                req_tuser,
   input  wire lfps_pkg::lfps_cfg_type              cfg,
   input  wire lfps_pkg::lfps_cmd_type              cmd,
   output lfps_pkg::lfps_sts_type                   sts,
   output logic [lfps_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int SUM_BITS = SAMPLE_BITS + 15;
   localparam int TOT_BITS = SAMPLE_BITS + 3;
   localparam int WPROD_BITS = SAMPLE_BITS + lfps_pkg::WEIGHT_BITS;
   localparam int ACC_BITS = lfps_pkg::ACC_BITS;

   // captured samples
   logic [SAMPLE_BITS-1:0] smp_ff [lfps_pkg::NUM_SAMPLES];

   // centroid sums and divider
   logic [SUM_BITS-1:0]             wsum_ff, wsum_in;
   logic [TOT_BITS-1:0]             tot_ff, tot_in;
   logic [SUM_BITS-1:0]             rem_ff, den_ff;
   logic [lfps_pkg::QUOT_BITS-1:0]  quot_ff;
   logic [SAMPLE_BITS-1:0]          smp_sel;
   logic [WPROD_BITS-1:0]           wprod;
   logic [SUM_BITS:0]               div_diff;
   logic                            div_ge;

   // controller state
   logic [lfps_pkg::POS_BITS-1:0]          pos_ff;
   logic signed [INTEGRAL_BITS-1:0]        esum_ff;
   logic signed [INTEGRAL_BITS:0]          esum_wide;
   logic signed [lfps_pkg::ERR_BITS-1:0]   prev_ff, err_ff;
   logic signed [lfps_pkg::DERIV_BITS-1:0] deriv_ff, err_wide;

   // multiplier and accumulator
   logic signed [lfps_pkg::ISUM_EXT_BITS-1:0] esum_ext;
   logic [lfps_pkg::GAIN_BITS-1:0]            gain;
   logic signed [lfps_pkg::MUL_A_BITS-1:0]    mul_a;
   logic signed [lfps_pkg::MUL_B_BITS-1:0]    mul_b;
   logic signed [lfps_pkg::PROD_BITS-1:0]     prod_ff;
   logic signed [ACC_BITS-1:0]                prod_ext, acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]                base_q, lsum, rsum;

   // output register
   logic [lfps_pkg::DUTY_BITS-1:0] left_ff, right_ff;
   logic [lfps_pkg::POS_BITS-1:0]  opos_ff;
   logic [lfps_pkg::ERR_BITS-1:0]  oerr_ff;

   // truncated duty clamped to 0..255
   function automatic logic [lfps_pkg::DUTY_BITS-1:0] duty_of(
      input logic signed [lfps_pkg::ACC_BITS-1:0] v);
      logic [lfps_pkg::DUTY_BITS-1:0] d;
      if (v[lfps_pkg::ACC_BITS-1]) begin
         d = '0;
      end else if (|v[lfps_pkg::ACC_BITS-1:lfps_pkg::FRAC_BITS+lfps_pkg::DUTY_BITS]) begin
         d = '1;
      end else begin
         d = v[lfps_pkg::FRAC_BITS+lfps_pkg::DUTY_BITS-1:lfps_pkg::FRAC_BITS];
      end
      return d;
   endfunction

   // sample capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < lfps_pkg::NUM_SAMPLES; k++) begin
            smp_ff[k] <= req_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
         end
      end
   end

   // weighted and plain sums, one sensor a cycle
   assign smp_sel = smp_ff[cmd.sum_sel];
   assign wprod   = smp_sel * lfps_pkg::weight_of(cmd.sum_sel);
   assign wsum_in = wsum_ff + SUM_BITS'(wprod);
   assign tot_in  = tot_ff + TOT_BITS'(smp_sel);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wsum_ff <= '0;
         tot_ff  <= '0;
      end else if (cmd.sum_en) begin
         wsum_ff <= wsum_in;
         tot_ff  <= tot_in;
      end
   end

   assign sts.total_zero = (tot_ff == '0);

   // restoring divider, one quotient bit a cycle
   assign div_diff = {1'b0, rem_ff} - {1'b0, den_ff};
   assign div_ge   = ~div_diff[SUM_BITS];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= wsum_ff;
         den_ff  <= {tot_ff, {(lfps_pkg::QUOT_BITS-1){1'b0}}};
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= div_diff[SUM_BITS-1:0];
         end
         den_ff  <= den_ff >> 1;
         quot_ff <= {quot_ff[lfps_pkg::QUOT_BITS-2:0], div_ge};
      end
   end

   // error and its saturating integral
   assign err_wide  = $signed({1'b0, pos_ff}) - $signed(14'(lfps_pkg::CENTRE));
   assign esum_wide = (INTEGRAL_BITS+1)'(esum_ff) + (INTEGRAL_BITS+1)'(err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         esum_ff <= '0;
         prev_ff <= '0;
      end else begin
         if (cmd.load && req_tuser) begin
            esum_ff <= '0;
            prev_ff <= '0;
         end
         if (cmd.pos_upd && !sts.total_zero) begin
            pos_ff <= quot_ff;
         end
         if (cmd.int_upd) begin
            if (esum_wide[INTEGRAL_BITS] != esum_wide[INTEGRAL_BITS-1]) begin
               esum_ff <= esum_wide[INTEGRAL_BITS] ?
                          $signed({1'b1, {(INTEGRAL_BITS-1){1'b0}}}) :
                          $signed({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
            end else begin
               esum_ff <= esum_wide[INTEGRAL_BITS-1:0];
            end
            prev_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_calc) begin
         err_ff <= err_wide[lfps_pkg::ERR_BITS-1:0];
      end
      if (cmd.int_upd) begin
         deriv_ff <= lfps_pkg::DERIV_BITS'(err_ff) - lfps_pkg::DERIV_BITS'(prev_ff);
      end
   end

   // shared multiplier, integral term split in two slices
   assign esum_ext = lfps_pkg::ISUM_EXT_BITS'(esum_ff);

   always_comb begin
      case (cmd.mul_sel)
         lfps_pkg::MUL_KI_LO: begin
            gain  = cfg.ki;
            mul_b = $signed({1'b0, esum_ext[lfps_pkg::SLICE_BITS-1:0]});
         end
         lfps_pkg::MUL_KI_HI: begin
            gain  = cfg.ki;
            mul_b = $signed({esum_ext[lfps_pkg::ISUM_EXT_BITS-1],
                             esum_ext[lfps_pkg::ISUM_EXT_BITS-1:lfps_pkg::SLICE_BITS]});
         end
         lfps_pkg::MUL_KP: begin
            gain  = cfg.kp;
            mul_b = lfps_pkg::MUL_B_BITS'(err_ff);
         end
         lfps_pkg::MUL_KD: begin
            gain  = cfg.kd;
            mul_b = lfps_pkg::MUL_B_BITS'(deriv_ff);
         end
         default: begin
            gain  = cfg.kp;
            mul_b = '0;
         end
      endcase
   end

   assign mul_a = $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // accumulator
   assign prod_ext = ACC_BITS'(prod_ff);

   always_comb begin
      case (cmd.acc_op)
         lfps_pkg::ACC_LOAD:   acc_in = prod_ext;
         lfps_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         lfps_pkg::ACC_ADD_HI: acc_in = acc_ff + (prod_ext <<< lfps_pkg::SLICE_BITS);
         lfps_pkg::ACC_CLAMP: begin
            if (acc_ff > lfps_pkg::TERM_LIMIT) begin
               acc_in = lfps_pkg::TERM_LIMIT;
            end else if (acc_ff < -lfps_pkg::TERM_LIMIT) begin
               acc_in = -lfps_pkg::TERM_LIMIT;
            end else begin
               acc_in = acc_ff;
            end
         end
         default:              acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // motor duties
   assign base_q = ACC_BITS'($signed({1'b0, cfg.base, {lfps_pkg::FRAC_BITS{1'b0}}}));
   assign lsum   = base_q + acc_ff;
   assign rsum   = base_q - acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         left_ff  <= duty_of(lsum);
         right_ff <= duty_of(rsum);
         opos_ff  <= pos_ff;
         oerr_ff  <= err_ff;
      end
   end

   assign rsp_tdata = {6'b0, oerr_ff, opos_ff, right_ff, left_ff};

endmodule

`default_nettype wire

@@ sv/lfps_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer: steps the datapath through sums, division, PID and output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire lfps_pkg::lfps_sts_type sts,
   output lfps_pkg::lfps_cmd_type      cmd
);

   lfps_pkg::lfps_state_type        state_ff, state_in;
   logic [lfps_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lfps_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = lfps_pkg::S_SUM;
            end
         end
         lfps_pkg::S_SUM: begin
            cmd.sum_en  = 1'b1;
            cmd.sum_sel = cnt_ff[2:0];
            if (cnt_ff == lfps_pkg::CNT_BITS'(lfps_pkg::NUM_SAMPLES-1)) begin
               state_in = lfps_pkg::S_DVI;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lfps_pkg::S_DVI: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = lfps_pkg::S_DIV;
         end
         lfps_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == lfps_pkg::CNT_BITS'(lfps_pkg::QUOT_BITS-1)) begin
               state_in = lfps_pkg::S_POS;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lfps_pkg::S_POS: begin
            cmd.pos_upd = 1'b1;
            state_in    = lfps_pkg::S_ERR;
         end
         lfps_pkg::S_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = lfps_pkg::S_INT;
         end
         lfps_pkg::S_INT: begin
            cmd.int_upd = 1'b1;
            cnt_in      = '0;
            state_in    = lfps_pkg::S_PID;
         end
         lfps_pkg::S_PID: begin
            // even steps multiply, odd steps accumulate; step four also clamps the integral term
            cmd.mul_en  = ~cnt_ff[0];
            cmd.mul_sel = lfps_pkg::lfps_mul_sel_type'(cnt_ff[2:1]);
            case (cnt_ff[2:0])
               3'd1:    cmd.acc_op = lfps_pkg::ACC_LOAD;
               3'd3:    cmd.acc_op = lfps_pkg::ACC_ADD_HI;
               3'd4:    cmd.acc_op = lfps_pkg::ACC_CLAMP;
               3'd5:    cmd.acc_op = lfps_pkg::ACC_ADD;
               3'd7:    cmd.acc_op = lfps_pkg::ACC_ADD;
               default: cmd.acc_op = lfps_pkg::ACC_HOLD;
            endcase
            if (cnt_ff == lfps_pkg::CNT_BITS'(lfps_pkg::PID_STEPS-1)) begin
               state_in = lfps_pkg::S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lfps_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = lfps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lfps_pkg::S_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfps_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lfps_chk.sv @@
// ----------------------------------------------------------------------------
// lfps_chk
// Port-level checks of the steering controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_chk (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [lfps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // only one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in flight");

   // centroid stays within the sensor span
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:16] <= 13'd6000)
      else $error("line position out of range");

   // error is position minus centre
   a_err_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:29] == 13'(rsp_tdata[28:16] - 13'd3000))
      else $error("line error inconsistent with position");

endmodule

bind line_follower_pid_steering lfps_chk u_lfps_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
